// ----- rtl/gkew_pkg.sv -----
// shared types and constants for the gaussian kernel edge weight block
package gkew_pkg;

   localparam int DIST_WIDTH      = 32;
   localparam int INDEX_WIDTH     = 8;
   localparam int SIGMA_WIDTH     = 24;
   localparam int FLOOR_WIDTH     = 17;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 24;
   localparam int REQ_DATA_WIDTH  = DIST_WIDTH + 2 * INDEX_WIDTH;
   localparam int RSP_DATA_WIDTH  = 32;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SCALING_ON   = 2'd0,
      CSR_INV_SIGMA_SQ = 2'd1,
      CSR_WEIGHT_FLOOR = 2'd2
   } csr_index_type;

   localparam logic                   SCALING_RESET = 1'b1;
   localparam logic [SIGMA_WIDTH-1:0] SIGMA_RESET   = 24'd655360;
   localparam logic [FLOOR_WIDTH-1:0] FLOOR_RESET   = 17'd32768;

   // squared distance times 1/sigma2, exact
   localparam int          SQ_WIDTH   = 2 * DIST_WIDTH;
   localparam int          PP_WIDTH   = DIST_WIDTH + SIGMA_WIDTH;
   localparam int          NUM_WIDTH  = SQ_WIDTH + SIGMA_WIDTH;
   localparam logic [63:0] ARG_LIMIT  = 64'd100000000 << 36;

   // g = n / (2^17 * 5^8), reciprocal estimate plus one correction
   localparam int                M_SHIFT     = 17;
   localparam int                M_WIDTH     = 46;
   localparam int                M_HI_WIDTH  = M_WIDTH - 32;
   localparam int                DIVC_WIDTH  = 19;
   localparam logic [18:0]       DIV_C       = 19'd390625;
   localparam int                R_SHIFT     = M_WIDTH;
   localparam int                RECIP_WIDTH = 28;
   localparam logic [27:0]       RECIP       = 28'((64'd1 << R_SHIFT) / 64'd390625);
   localparam int                RHI_WIDTH   = M_HI_WIDTH + RECIP_WIDTH;
   localparam int                RLO_WIDTH   = 32 + RECIP_WIDTH;
   localparam int                RSUM_WIDTH  = RLO_WIDTH + M_HI_WIDTH;
   localparam int                QE_WIDTH    = RSUM_WIDTH - R_SHIFT;
   localparam int                QC_WIDTH    = QE_WIDTH + DIVC_WIDTH;

   // taylor terms in q0.31
   localparam int Q_FRAC   = 31;
   localparam int G_WIDTH  = 27;
   localparam int T2_WIDTH = 23;
   localparam int T3_WIDTH = 19;
   localparam int T4_WIDTH = 15;
   localparam int T5_WIDTH = 11;

   localparam int          DIV3_SHIFT  = 20;
   localparam logic [18:0] DIV3_RECIP  = 19'd349526;
   localparam int          DIV15_SHIFT = 12;
   localparam logic [8:0]  DIV15_RECIP = 9'd274;
   localparam int          P3_WIDTH    = (T3_WIDTH - 1) + 19;
   localparam int          P4_WIDTH    = (T4_WIDTH - 3) + 19;
   localparam int          P5_WIDTH    = (T5_WIDTH - 3) + 9;

   localparam int                 V_WIDTH   = 32;
   localparam logic [V_WIDTH-1:0] V_ONE     = 32'h8000_0000;
   localparam logic [63:0]        SQ_ROUND  = 64'h4000_0000;
   localparam int                 SQUARINGS = 8;
   localparam int                 W_SHIFT   = 15;
   localparam logic [32:0]        W_ROUND   = 33'h0_0000_4000;

   localparam int NUM_STAGES = 22;

   typedef struct packed {
      logic [DIST_WIDTH-1:0] distance;
      logic                  diag;
      logic                  big;
   } side_type;

endpackage

// ----- rtl/gaussian_kernel_edge_weight.sv -----
// gaussian kernel edge weight pipeline, top level
//
// req channel carries one distance-matrix entry per beat (distance in
// unsigned q24.8, row and column index). rsp channel returns one beat per
// request, in order: the q0.16 kernel weight exp(-(d/10000)^2 / sigma2) with
// a kept flag, or the raw distance with kept low when scaling is off.
// with scaling on, weights under weight_floor and diagonal entries come back as zero.
// csr port writes scaling_on, inv_sigma_sq and weight_floor; write only
// while no beats are in flight.
// one beat is taken every cycle unless a waiting beat is stalled by rsp_tready
// low. from the accepting edge to rsp_tvalid lie 22 register stages plus the
// output register, set by the chain of multipliers (square, scale, reciprocal
// divide, four taylor terms, eight squarings), each one multiply deep.
// a synchronous reset clears the valid bits and loads the register
// defaults (scaling on, 1/sigma2 = 10.0, floor = 0.5). when the receiver
// holds rsp_tready low with a beat waiting, the whole pipeline freezes and
// req_tready drops in the same cycle; nothing is lost or repeated.
module gaussian_kernel_edge_weight (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // distance [31:0], row_index [39:32], col_index [47:40]
   input  logic [gkew_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // result_value [31:0]
   output logic [gkew_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   // kept [0]
   output logic                                 rsp_tuser,
   input  logic                                 csr_wr_en,
   input  logic [gkew_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [gkew_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import gkew_pkg::*;

   logic                   scaling_on_ff, scaling_on_in;
   logic [SIGMA_WIDTH-1:0] inv_sigma_sq_ff, inv_sigma_sq_in;
   logic [FLOOR_WIDTH-1:0] weight_floor_ff, weight_floor_in;

   logic                  advance;
   logic [NUM_STAGES:1]   vld_ff, vld_in;
   side_type              side_ff [1:NUM_STAGES];
   side_type              side_in [1:NUM_STAGES];

   logic [DIST_WIDTH-1:0]  req_distance;
   logic [INDEX_WIDTH-1:0] req_row, req_col;

   logic [SQ_WIDTH-1:0]    dsq_ff, dsq_in;
   logic [PP_WIDTH-1:0]    phi_ff, phi_in, plo_ff, plo_in;
   logic [NUM_WIDTH-1:0]   num_ff, num_in;
   logic                   big_in;
   logic [M_WIDTH-1:0]     m4_ff, m4_in, m5_ff, m6_ff, m7_ff;
   logic [RHI_WIDTH-1:0]   rhi_ff, rhi_in;
   logic [RLO_WIDTH-1:0]   rlo_ff, rlo_in;
   logic [RSUM_WIDTH-1:0]  rsum;
   logic [QE_WIDTH-1:0]    qe6_ff, qe6_in, qe7_ff, qe_inc;
   logic [QC_WIDTH-1:0]    qc_ff, qc_in, rem;
   logic [G_WIDTH-1:0]     g8_ff, g8_in, g9_ff, g10_ff, g11_ff, g12_ff, g13_ff;
   logic [2*G_WIDTH-1:0]   gg;
   logic [T2_WIDTH+G_WIDTH-1:0] t2g;
   logic [T3_WIDTH+G_WIDTH-1:0] t3g;
   logic [T4_WIDTH+G_WIDTH-1:0] t4g;
   logic [T2_WIDTH-1:0]    t2_9_ff, t2_9_in, t2_10_ff, t2_11_ff, t2_12_ff, t2_13_ff;
   logic [T3_WIDTH-1:0]    t3_10_ff, t3_10_in, t3_11_ff, t3_12_ff;
   logic [T4_WIDTH-1:0]    t4_11_ff, t4_11_in, t4_12_ff;
   logic [T5_WIDTH-1:0]    t5_12_ff, t5_12_in;
   logic [P3_WIDTH-1:0]    p3_ff, p3_in;
   logic [P4_WIDTH-1:0]    p4_ff, p4_in;
   logic [P5_WIDTH-1:0]    p5_ff, p5_in;
   logic [V_WIDTH+1:0]     v_sum;
   logic [V_WIDTH-1:0]     sq_ff [0:SQUARINGS];
   logic [V_WIDTH-1:0]     sq_in [0:SQUARINGS];
   logic [63:0]            sq_prod [1:SQUARINGS];

   logic [V_WIDTH:0]            w_sum;
   logic [FLOOR_WIDTH-1:0]      weight;
   logic                        keep;
   logic                        rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_WIDTH-1:0]   rsp_tdata_ff, rsp_tdata_in;
   logic                        rsp_tuser_ff, rsp_tuser_in;

   // configuration registers
   always_comb begin
      scaling_on_in   = scaling_on_ff;
      inv_sigma_sq_in = inv_sigma_sq_ff;
      weight_floor_in = weight_floor_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SCALING_ON:   scaling_on_in   = csr_wdata[0];
            CSR_INV_SIGMA_SQ: inv_sigma_sq_in = csr_wdata[SIGMA_WIDTH-1:0];
            CSR_WEIGHT_FLOOR: weight_floor_in = csr_wdata[FLOOR_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scaling_on_ff   <= SCALING_RESET;
         inv_sigma_sq_ff <= SIGMA_RESET;
         weight_floor_ff <= FLOOR_RESET;
      end else begin
         scaling_on_ff   <= scaling_on_in;
         inv_sigma_sq_ff <= inv_sigma_sq_in;
         weight_floor_ff <= weight_floor_in;
      end
   end

   // pipeline flow control
   assign advance    = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = advance;

   assign req_distance = req_tdata[DIST_WIDTH-1:0];
   assign req_row      = req_tdata[DIST_WIDTH +: INDEX_WIDTH];
   assign req_col      = req_tdata[DIST_WIDTH+INDEX_WIDTH +: INDEX_WIDTH];

   always_comb begin
      vld_in = {vld_ff[NUM_STAGES-1:1], req_tvalid};
      side_in[1].distance = req_distance;
      side_in[1].diag     = (req_row == req_col);
      side_in[1].big      = 1'b0;
      for (int k = 2; k <= NUM_STAGES; k++) begin
         side_in[k] = side_ff[k-1];
      end
      side_in[4].big = big_in;
   end

   // datapath
   always_comb begin
      dsq_in = req_distance * req_distance;

      phi_in = dsq_ff[SQ_WIDTH-1:DIST_WIDTH] * inv_sigma_sq_ff;
      plo_in = dsq_ff[DIST_WIDTH-1:0] * inv_sigma_sq_ff;

      num_in = (NUM_WIDTH'(phi_ff) << DIST_WIDTH) + NUM_WIDTH'(plo_ff);

      big_in = (num_ff >= NUM_WIDTH'(ARG_LIMIT));
      m4_in  = num_ff[M_SHIFT+M_WIDTH-1:M_SHIFT];

      rhi_in = m4_ff[M_WIDTH-1:32] * RECIP;
      rlo_in = m4_ff[31:0] * RECIP;

      rsum   = (RSUM_WIDTH'(rhi_ff) << 32) + RSUM_WIDTH'(rlo_ff);
      qe6_in = rsum[RSUM_WIDTH-1:R_SHIFT];

      qc_in  = qe6_ff * DIV_C;

      rem    = QC_WIDTH'(m7_ff) - qc_ff;
      qe_inc = qe7_ff + QE_WIDTH'(1);
      g8_in  = (rem >= QC_WIDTH'(DIV_C)) ? qe_inc[G_WIDTH-1:0] : qe7_ff[G_WIDTH-1:0];

      gg       = g8_ff * g8_ff;
      t2_9_in  = gg[Q_FRAC+T2_WIDTH-1:Q_FRAC];
      t2g      = t2_9_ff * g9_ff;
      t3_10_in = t2g[Q_FRAC+T3_WIDTH-1:Q_FRAC];
      t3g      = t3_10_ff * g10_ff;
      t4_11_in = t3g[Q_FRAC+T4_WIDTH-1:Q_FRAC];
      t4g      = t4_11_ff * g11_ff;
      t5_12_in = t4g[Q_FRAC+T5_WIDTH-1:Q_FRAC];

      // t3/6, t4/24, t5/120 by reciprocal
      p3_in = t3_12_ff[T3_WIDTH-1:1] * DIV3_RECIP;
      p4_in = t4_12_ff[T4_WIDTH-1:3] * DIV3_RECIP;
      p5_in = t5_12_ff[T5_WIDTH-1:3] * DIV15_RECIP;

      v_sum = (V_WIDTH+2)'(V_ONE)
            + (V_WIDTH+2)'(t2_13_ff[T2_WIDTH-1:1])
            + (V_WIDTH+2)'(p4_ff[P4_WIDTH-1:DIV3_SHIFT])
            - (V_WIDTH+2)'(g13_ff)
            - (V_WIDTH+2)'(p3_ff[P3_WIDTH-1:DIV3_SHIFT])
            - (V_WIDTH+2)'(p5_ff[P5_WIDTH-1:DIV15_SHIFT]);
      sq_in[0] = v_sum[V_WIDTH-1:0];

      for (int k = 1; k <= SQUARINGS; k++) begin
         sq_prod[k] = sq_ff[k-1] * sq_ff[k-1] + SQ_ROUND;
         sq_in[k]   = sq_prod[k][Q_FRAC+V_WIDTH-1:Q_FRAC];
      end

      w_sum  = V_WIDTH'(0) + {1'b0, sq_ff[SQUARINGS]} + W_ROUND;
      weight = side_ff[NUM_STAGES].big ? '0 : w_sum[W_SHIFT+FLOOR_WIDTH-1:W_SHIFT];
      keep   = !side_ff[NUM_STAGES].diag && (weight >= weight_floor_ff);

      rsp_tvalid_in = vld_ff[NUM_STAGES];
      if (scaling_on_ff) begin
         rsp_tdata_in = keep ? RSP_DATA_WIDTH'(weight) : '0;
         rsp_tuser_in = keep;
      end else begin
         rsp_tdata_in = side_ff[NUM_STAGES].distance;
         rsp_tuser_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else if (advance) begin
         vld_ff        <= vld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 1; k <= NUM_STAGES; k++) begin
            side_ff[k] <= side_in[k];
         end
         dsq_ff   <= dsq_in;
         phi_ff   <= phi_in;
         plo_ff   <= plo_in;
         num_ff   <= num_in;
         m4_ff    <= m4_in;
         rhi_ff   <= rhi_in;
         rlo_ff   <= rlo_in;
         m5_ff    <= m4_ff;
         qe6_ff   <= qe6_in;
         m6_ff    <= m5_ff;
         qc_ff    <= qc_in;
         qe7_ff   <= qe6_ff;
         m7_ff    <= m6_ff;
         g8_ff    <= g8_in;
         t2_9_ff  <= t2_9_in;
         g9_ff    <= g8_ff;
         t3_10_ff <= t3_10_in;
         t2_10_ff <= t2_9_ff;
         g10_ff   <= g9_ff;
         t4_11_ff <= t4_11_in;
         t3_11_ff <= t3_10_ff;
         t2_11_ff <= t2_10_ff;
         g11_ff   <= g10_ff;
         t5_12_ff <= t5_12_in;
         t4_12_ff <= t4_11_ff;
         t3_12_ff <= t3_11_ff;
         t2_12_ff <= t2_11_ff;
         g12_ff   <= g11_ff;
         p3_ff    <= p3_in;
         p4_ff    <= p4_in;
         p5_ff    <= p5_in;
         t2_13_ff <= t2_12_ff;
         g13_ff   <= g12_ff;
         for (int k = 0; k <= SQUARINGS; k++) begin
            sq_ff[k] <= sq_in[k];
         end
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= rsp_tuser_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

`ifndef SYNTHESIS
   a_kept_weight_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[RSP_DATA_WIDTH-1:FLOOR_WIDTH] == '0)
      else $error("kept beat carries a weight above one");

   a_stall_freezes_pipe: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(vld_ff))
      else $error("valid bits moved during a stall");

   a_square_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NUM_STAGES] |-> sq_ff[SQUARINGS] <= V_ONE)
      else $error("squared exponential exceeds one");
`endif

endmodule

// ----- tb/tb.sv -----
// testbench for gaussian_kernel_edge_weight: directed entries, then random register settings
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import gkew_pkg::*;

   localparam int         NUM_PHASES    = 8;
   localparam int         PHASE_BEATS   = 116;
   localparam int         PLAN_LEN      = 33;
   localparam int         IDLE_LIMIT    = 4000;
   localparam int         SETTLE_CYCLES = 40;
   // spare index, ignored by the block
   localparam logic [1:0] CSR_SPARE     = 2'd3;
   localparam bit [63:0]  ARG_DIV       = 64'd100000000;
   localparam bit [63:0]  ARG_CEIL      = ARG_DIV << 36;
   localparam bit [63:0]  Q31_ONE       = 64'h8000_0000;

   typedef enum logic {BEAT, WRITE} step_kind_type;
   typedef enum logic [1:0] {FLOW_OPEN, FLOW_RANDOM, FLOW_PERIODIC, FLOW_CHOKED} flow_mode_type;

   typedef struct packed {
      step_kind_type kind;
      logic [1:0]    reg_index;
      logic [31:0]   data;
      logic [7:0]    row;
      logic [7:0]    col;
      logic          typed;
      logic [31:0]   want_value;
      logic          want_kept;
   } plan_step_type;

   typedef struct packed {
      logic [31:0] value;
      logic        kept;
   } weight_result_type;

   localparam plan_step_type PLAN [PLAN_LEN] = '{
      '{BEAT,  CSR_SPARE,        32'd0,         8'd0,   8'd1,   1'b1, 32'd65536, 1'b1},
      '{BEAT,  CSR_SPARE,        32'd0,         8'd7,   8'd7,   1'b1, 32'd0,     1'b0},
      '{BEAT,  CSR_SPARE,        32'hFFFF_FFFF, 8'd0,   8'd255, 1'b1, 32'd0,     1'b0},
      '{BEAT,  CSR_SPARE,        32'd256000,    8'd255, 8'd0,   1'b0, 32'd0,     1'b0},
      '{BEAT,  CSR_SPARE,        32'd1,         8'd18,  8'd129, 1'b0, 32'd0,     1'b0},
      '{BEAT,  CSR_SPARE,        32'd2560000,   8'd1,   8'd2,   1'b0, 32'd0,     1'b0},
      '{BEAT,  CSR_SPARE,        32'h8000_0000, 8'd255, 8'd255, 1'b1, 32'd0,     1'b0},
      '{WRITE, CSR_WEIGHT_FLOOR, 32'd0,         8'd0,   8'd0,   1'b0, 32'd0,     1'b0},
      '{BEAT,  CSR_SPARE,        32'hFFFF_FFFF, 8'd1,   8'd2,   1'b1, 32'd0,     1'b1},
      '{BEAT,  CSR_SPARE,        32'd3000000,   8'd2,   8'd1,   1'b0, 32'd0,     1'b0},
      '{BEAT,  CSR_SPARE,        32'hFFFF_FFFF, 8'd200, 8'd200, 1'b1, 32'd0,     1'b0},
      '{WRITE, CSR_INV_SIGMA_SQ, 32'd0,         8'd0,   8'd0,   1'b0, 32'd0,     1'b0},
      '{BEAT,  CSR_SPARE,        32'hFFFF_FFFF, 8'd3,   8'd4,   1'b1, 32'd65536, 1'b1},
      '{WRITE, CSR_WEIGHT_FLOOR, 32'd65536,     8'd0,   8'd0,   1'b0, 32'd0,     1'b0},
      '{BEAT,  CSR_SPARE,        32'd12345678,  8'd170, 8'd85,  1'b1, 32'd65536, 1'b1},
      '{WRITE, CSR_WEIGHT_FLOOR, 32'h0001_0001, 8'd0,   8'd0,   1'b0, 32'd0,     1'b0},
      '{BEAT,  CSR_SPARE,        32'd0,         8'd85,  8'd170, 1'b1, 32'd0,     1'b0},
      '{WRITE, CSR_INV_SIGMA_SQ, 32'h00FF_FFFF, 8'd0,   8'd0,   1'b0, 32'd0,     1'b0},
      '{WRITE, CSR_WEIGHT_FLOOR, 32'd0,         8'd0,   8'd0,   1'b0, 32'd0,     1'b0},
      '{BEAT,  CSR_SPARE,        32'd1,         8'd0,   8'd128, 1'b0, 32'd0,     1'b0},
      '{BEAT,  CSR_SPARE,        32'h0000_FFFF, 8'd9,   8'd10,  1'b0, 32'd0,     1'b0},
      '{BEAT,  CSR_SPARE,        32'hFFFF_FFFF, 8'd9,   8'd8,   1'b1, 32'd0,     1'b1},
      '{WRITE, CSR_INV_SIGMA_SQ, 32'd1,         8'd0,   8'd0,   1'b0, 32'd0,     1'b0},
      '{BEAT,  CSR_SPARE,        32'hFFFF_FFFF, 8'd4,   8'd3,   1'b0, 32'd0,     1'b0},
      '{WRITE, CSR_SPARE,        32'h00FF_FFFF, 8'd0,   8'd0,   1'b0, 32'd0,     1'b0},
      '{BEAT,  CSR_SPARE,        32'h0100_0000, 8'd127, 8'd128, 1'b0, 32'd0,     1'b0},
      '{BEAT,  CSR_SPARE,        32'h000F_FFFF, 8'd64,  8'd32,  1'b0, 32'd0,     1'b0},
      '{WRITE, CSR_SCALING_ON,   32'd0,         8'd0,   8'd0,   1'b0, 32'd0,     1'b0},
      '{BEAT,  CSR_SPARE,        32'hDEAD_BEEF, 8'd1,   8'd2,   1'b1, 32'hDEAD_BEEF, 1'b0},
      '{BEAT,  CSR_SPARE,        32'hFFFF_FFFF, 8'd6,   8'd6,   1'b1, 32'hFFFF_FFFF, 1'b0},
      '{BEAT,  CSR_SPARE,        32'd0,         8'd0,   8'd0,   1'b1, 32'd0,     1'b0},
      '{WRITE, CSR_SCALING_ON,   32'h00FF_FFFE, 8'd0,   8'd0,   1'b0, 32'd0,     1'b0},
      '{BEAT,  CSR_SPARE,        32'h5555_5555, 8'd3,   8'd9,   1'b1, 32'h5555_5555, 1'b0}
   };

   logic                        clock      = 1'b0;
   logic                        reset      = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [REQ_DATA_WIDTH-1:0]   req_tdata  = '0;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0]   rsp_tdata;
   logic                        rsp_tuser;
   logic                        csr_wr_en  = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0]  csr_index  = '0;
   logic [CSR_DATA_WIDTH-1:0]   csr_wdata  = '0;

   logic                        scale_mirror = SCALING_RESET;
   logic [SIGMA_WIDTH-1:0]      sigma_mirror = SIGMA_RESET;
   logic [FLOOR_WIDTH-1:0]      floor_mirror = FLOOR_RESET;

   weight_result_type pending_weights [$];
   int                burst_left  = 0;
   int                beats_sent  = 0;
   int                reg_writes  = 0;
   int                kept_seen   = 0;
   int                failures    = 0;
   int                idle_cycles = 0;
   flow_mode_type     flow_mode   = FLOW_OPEN;
   int                flow_left   = 0;

   gaussian_kernel_edge_weight DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // exp(-(d/10000)^2 * inv_sigma) in q0.16, taylor series then eight squarings
   function automatic logic [31:0] kernel_weight(logic [31:0] distance, logic [23:0] inv_sigma);
      bit [63:0] sq, hi, lo, num, g, t2, t3, t4, t5, v;
      int        k;
      sq = 64'(distance) * 64'(distance);
      hi = (sq >> 32) * 64'(inv_sigma);
      lo = (sq & 64'hFFFF_FFFF) * 64'(inv_sigma);
      if (hi[63:32] != 0)
         return 32'd0;
      num = hi << 32;
      if (lo > ~num)
         return 32'd0;
      num = num + lo;
      if (num >= ARG_CEIL)
         return 32'd0;
      g  = (num / ARG_DIV) >> 9;
      t2 = (g * g) >> 31;
      t3 = (t2 * g) >> 31;
      t4 = (t3 * g) >> 31;
      t5 = (t4 * g) >> 31;
      v  = Q31_ONE + t2 / 2 + t4 / 24;
      v  = v - g - t3 / 6 - t5 / 120;
      for (k = 0; k < 8; k++)
         v = (v * v + 64'h4000_0000) >> 31;
      return 32'((v + 64'h4000) >> 15);
   endfunction

   function automatic weight_result_type predict_entry(logic [31:0] distance, logic [7:0] row,
                                                       logic [7:0] col);
      weight_result_type res;
      logic [31:0]       w;
      if (!scale_mirror) begin
         res.value = distance;
         res.kept  = 1'b0;
         return res;
      end
      w         = kernel_weight(distance, sigma_mirror);
      res.kept  = (row != col) && (w >= {15'd0, floor_mirror});
      res.value = res.kept ? w : 32'd0;
      return res;
   endfunction

   task automatic send_entry(input logic [31:0] distance, input logic [7:0] row,
                             input logic [7:0] col, input logic typed,
                             input weight_result_type want);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {col, row, distance};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_weights.push_back(typed ? want : predict_entry(distance, row, col));
      burst_left--;
      beats_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_weights.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [23:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (index)
         CSR_SCALING_ON:   scale_mirror = value[0];
         CSR_INV_SIGMA_SQ: sigma_mirror = value;
         CSR_WEIGHT_FLOOR: floor_mirror = value[16:0];
         default: ;
      endcase
      reg_writes++;
      @(posedge clock);
   endtask

   // receiver pattern
   always @(posedge clock) begin
      if (flow_left == 0) begin
         flow_mode <= flow_mode_type'($urandom_range(0, 3));
         flow_left <= $urandom_range(5, 60);
      end else begin
         flow_left <= flow_left - 1;
      end
      case (flow_mode)
         FLOW_OPEN:     rsp_tready <= 1'b1;
         FLOW_RANDOM:   rsp_tready <= ($urandom_range(0, 3) != 0);
         FLOW_PERIODIC: rsp_tready <= (flow_left % 3 != 0);
         default:       rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   always @(posedge clock) begin
      weight_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_weights.size() == 0) begin
            $error("rsp beat with nothing outstanding: result_value %h kept %b",
                   rsp_tdata, rsp_tuser);
            failures++;
         end else begin
            want = pending_weights.pop_front();
            if (rsp_tdata !== want.value) begin
               $error("result_value: expected %h, got %h", want.value, rsp_tdata);
               failures++;
            end
            if (rsp_tuser !== want.kept) begin
               $error("kept: expected %b, got %b", want.kept, rsp_tuser);
               failures++;
            end
            if (want.kept)
               kept_seen++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("gaussian_kernel_edge_weight test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int                step, phase, n;
      weight_result_type want;
      logic [31:0]       distance;
      logic [7:0]        row, col;
      logic [23:0]       sigma;
      logic [16:0]       floor_val;
      logic [6:0]        pad;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (step = 0; step < PLAN_LEN; step++) begin
         if (PLAN[step].kind == WRITE) begin
            wait_idle();
            write_reg(PLAN[step].reg_index, PLAN[step].data[23:0]);
         end else begin
            want.value = PLAN[step].want_value;
            want.kept  = PLAN[step].want_kept;
            send_entry(PLAN[step].data, PLAN[step].row, PLAN[step].col,
                       PLAN[step].typed, want);
         end
      end

      for (phase = 0; phase < NUM_PHASES; phase++) begin
         wait_idle();
         write_reg(CSR_SCALING_ON, {23'($urandom), ($urandom_range(0, 3) != 0)});
         case ($urandom_range(0, 7))
            0:       sigma = 24'hFF_FFFF;
            1:       sigma = 24'd1;
            2:       sigma = SIGMA_RESET;
            default: sigma = 24'($urandom_range(1, 24'hFF_FFFF) >> $urandom_range(0, 22));
         endcase
         write_reg(CSR_INV_SIGMA_SQ, sigma);
         case ($urandom_range(0, 7))
            0:       floor_val = 17'd0;
            1:       floor_val = 17'd65536;
            2:       floor_val = 17'($urandom_range(65537, 131071));
            3:       floor_val = FLOOR_RESET;
            default: floor_val = 17'($urandom_range(0, 65535));
         endcase
         pad = 7'($urandom);
         write_reg(CSR_WEIGHT_FLOOR, {pad, floor_val});
         write_reg(CSR_SPARE, 24'($urandom));
         for (n = 0; n < PHASE_BEATS; n++) begin
            case ($urandom_range(0, 9))
               0:       distance = $urandom;
               1:       distance = 32'd0;
               default: distance = $urandom >> $urandom_range(0, 31);
            endcase
            row = 8'($urandom);
            col = ($urandom_range(0, 3) == 0) ? row : 8'($urandom);
            send_entry(distance, row, col, 1'b0, '0);
         end
      end

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("%0d matrix entries over %0d register writes, %0d weights kept",
               beats_sent, reg_writes, kept_seen);
      if (failures == 0)
         $display("gaussian_kernel_edge_weight test passed");
      else
         $display("gaussian_kernel_edge_weight test failed");
      $finish;
   end

endmodule
